FILE: hw/rtl/ltcd_pkg.sv
// ----------------------------------------------------------------------------
// ltcd_pkg
// Types and fixed field widths shared by the LRU cache directory block.
// ----------------------------------------------------------------------------
package ltcd_pkg;

  // Fixed widths of the stream fields.
  localparam int TAG_IN_BITS = 32;
  localparam int TIME_BITS   = 32;
  localparam int SLOT_BITS   = 7;
  localparam int EVK_BITS    = 32;
  localparam int S_TDATA_W   = TAG_IN_BITS + TIME_BITS;
  localparam int M_TDATA_W   = 48;

  // Operation carried in the request tuser.
  typedef enum logic {
    FUNC_LOOKUP = 1'b0,
    FUNC_FLUSH  = 1'b1
  } func_t;

  // Controller states, one-hot.
  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_SCAN  = 5'b00100,
    S_WRITE = 5'b01000,
    S_FLUSH = 5'b10000
  } state_t;

endpackage

FILE: hw/rtl/ltcd_ram.sv
// ----------------------------------------------------------------------------
// ltcd_ram
// Generic single-clock RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
module ltcd_ram #(
  parameter int WIDTH = 65,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/lru_tagged_cache_directory_unit.sv
// ----------------------------------------------------------------------------
// lru_tagged_cache_directory_unit
// Fully associative cache directory with timestamp LRU replacement.
// ----------------------------------------------------------------------------
// A request beat either looks up a key tag or flushes the directory. A lookup
// walks every entry of the directory RAM in index order, one read per cycle;
// a match refreshes that entry's last-use time and reports a hit, otherwise
// the key goes into the first empty entry or, with none empty, replaces the
// valid entry with the smallest last-use time (lowest index on a tie), and
// the replaced tag is reported. On a miss the walk reads every entry through
// the single read port of the directory RAM, then the result beat is
// presented from S_WRITE once the output register is free, and the next
// request is taken in S_IDLE after it. A hit ends the walk early. A flush,
// and likewise the period after reset, runs a clearing pass that writes
// every entry empty, one per cycle, during which no request is accepted; a
// flush then presents one all-zero result beat from S_FLUSH. One request
// is in work at a time, but a new request is taken while the previous
// result still waits in the output register.
// ----------------------------------------------------------------------------
module lru_tagged_cache_directory_unit
  import ltcd_pkg::*;
#(
  parameter int ENTRIES  = 128,
  parameter int KEY_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  // Request channel.
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // [31:0] key_tag, [63:32] now_time
  input  logic                 s_tuser,   // [0] func
  // Result channel.
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata    // [0] hit, [7:1] slot_index,
                                          // [8] evicted, [40:9] evicted_key,
                                          // [47:41] zero
);

  localparam int IDX_W  = $clog2(ENTRIES);
  localparam int CNT_W  = $clog2(ENTRIES + 1);
  localparam int WORD_W = 1 + KEY_BITS + TIME_BITS;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  state_t state;

  // Request held for the duration of the walk.
  logic [KEY_BITS-1:0]  req_key;
  logic [TIME_BITS-1:0] req_time;
  logic                 flush_pending;

  // Walk control: read issue counter and the index whose data returns now.
  logic [CNT_W-1:0] issue_cnt;
  logic             pend_valid;
  logic [IDX_W-1:0] pend_idx;
  logic [IDX_W-1:0] clr_idx;

  // Running search results.
  logic                 hit_r;
  logic [IDX_W-1:0]     match_idx;
  logic                 have_free;
  logic [IDX_W-1:0]     free_idx;
  logic                 have_old;
  logic [IDX_W-1:0]     old_idx;
  logic [TIME_BITS-1:0] old_time;
  logic [KEY_BITS-1:0]  old_key;

  // RAM port signals.
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic              ram_re;
  logic [IDX_W-1:0]  ram_raddr;
  logic [WORD_W-1:0] ram_rdata;

  // Fields of the word coming back from the RAM.
  logic                 rd_valid;
  logic [KEY_BITS-1:0]  rd_key;
  logic [TIME_BITS-1:0] rd_time;

  // Request decode.
  logic [KEY_BITS+TAG_IN_BITS-1:0] key_wide;
  logic                            in_beat;
  logic                            out_free;
  logic                            res_load;

  // Result assembly.
  logic [IDX_W-1:0]             slot;
  logic                         evict;
  logic [IDX_W+SLOT_BITS-1:0]   slot_wide;
  logic [KEY_BITS+EVK_BITS-1:0] evk_wide;

  ltcd_ram #(
    .WIDTH (WORD_W),
    .DEPTH (ENTRIES)
  ) u_dir_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign s_tready = (state == S_IDLE);
  assign in_beat  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // A result beat is loaded into the output register in this cycle.
  assign res_load = out_free && ((state == S_WRITE) || (state == S_FLUSH));

  // The tag is taken to KEY_BITS: truncated when narrower, zero-filled when wider.
  assign key_wide = {{KEY_BITS{1'b0}}, s_tdata[TAG_IN_BITS-1:0]};

  assign {rd_valid, rd_key, rd_time} = ram_rdata;

  // The word layout is {valid, key, time}.
  assign ram_re    = (state == S_SCAN) && (issue_cnt < CNT_W'(ENTRIES));
  assign ram_raddr = issue_cnt[IDX_W-1:0];

  // Victim choice once the walk is over: a hit keeps its entry, otherwise
  // the first empty entry wins over the oldest one.
  assign slot  = hit_r ? match_idx : (have_free ? free_idx : old_idx);
  assign evict = !hit_r && !have_free;

  assign slot_wide = {{SLOT_BITS{1'b0}}, slot};
  assign evk_wide  = {{EVK_BITS{1'b0}}, old_key};

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_idx;
    ram_wdata = '0;
    case (state)
      S_CLEAR: begin
        ram_we = 1'b1;
      end
      S_WRITE: begin
        ram_we    = out_free;
        ram_waddr = slot;
        ram_wdata = {1'b1, req_key, req_time};
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_idx       <= '0;
      flush_pending <= 1'b0;
      pend_valid    <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      pend_valid <= ram_re;
      if (m_tvalid && m_tready && !res_load) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        S_CLEAR: begin
          if (clr_idx == LAST_IDX) begin
            clr_idx <= '0;
            state   <= flush_pending ? S_FLUSH : S_IDLE;
          end else begin
            clr_idx <= clr_idx + 1'b1;
          end
        end

        S_IDLE: begin
          if (in_beat) begin
            if (func_t'(s_tuser) == FUNC_FLUSH) begin
              flush_pending <= 1'b1;
              clr_idx       <= '0;
              state         <= S_CLEAR;
            end else begin
              issue_cnt <= '0;
              hit_r     <= 1'b0;
              have_free <= 1'b0;
              have_old  <= 1'b0;
              state     <= S_SCAN;
            end
          end
        end

        S_SCAN: begin
          if (ram_re) begin
            issue_cnt <= issue_cnt + 1'b1;
          end
          if (pend_valid) begin
            if (rd_valid && (rd_key == req_key)) begin
              hit_r     <= 1'b1;
              match_idx <= pend_idx;
              state     <= S_WRITE;
            end else begin
              // The oldest entry is only sought ahead of the first empty one.
              if (!have_free) begin
                if (!rd_valid) begin
                  have_free <= 1'b1;
                  free_idx  <= pend_idx;
                end else if (!have_old || (old_time > rd_time)) begin
                  have_old <= 1'b1;
                  old_idx  <= pend_idx;
                  old_time <= rd_time;
                  old_key  <= rd_key;
                end
              end
              if (pend_idx == LAST_IDX) begin
                state <= S_WRITE;
              end
            end
          end
        end

        S_WRITE: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {7'b0,
                         evict ? evk_wide[EVK_BITS-1:0] : {EVK_BITS{1'b0}},
                         evict,
                         slot_wide[SLOT_BITS-1:0],
                         hit_r};
            state    <= S_IDLE;
          end
        end

        S_FLUSH: begin
          if (out_free) begin
            flush_pending <= 1'b0;
            m_tvalid      <= 1'b1;
            m_tdata       <= '0;
            state         <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      req_key  <= key_wide[KEY_BITS-1:0];
      req_time <= s_tdata[S_TDATA_W-1:TAG_IN_BITS];
    end
    pend_idx <= ram_raddr;
  end

  // The directory RAM is never read and written in the same cycle.
  a_ram_port_excl : assert property (@(posedge clk) disable iff (rst)
    !(ram_we && ram_re))
    else $error("directory RAM read and write collide");

  // A miss with no empty entry always has a valid victim to replace.
  a_victim_found : assert property (@(posedge clk) disable iff (rst)
    (state == S_WRITE) && !hit_r && !have_free |-> have_old)
    else $error("replacement without a victim");

  // A result beat appears only out of the write-back or the flush response.
  a_result_source : assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == S_WRITE) || ($past(state) == S_FLUSH))
    else $error("result beat raised outside write-back");

  // No request is taken while the clearing pass runs.
  a_clear_blocks : assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !s_tready)
    else $error("request accepted during clearing pass");

endmodule
